@@ rtl/core/fmsp_pkg.sv @@
// ----------------------------------------------------------------------------
// File mode string parser package
// Shared item types, parser state and character codes.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    // Permission bits of a full mode word.
    localparam logic [11:0] MODE_MASK = 12'o7777;

    // Parse phase of the current string.
    typedef enum logic [1:0] {
        PH_START,
        PH_OCTAL,
        PH_WHO,
        PH_PERM
    } phase_t;

    // Operator of the current symbolic segment.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    // One input item: a character of the mode string plus sampled file data.
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [11:0] current_mode;
        logic        is_dir;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [11:0] mode_bits;
        logic        invalid;
    } out_item_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic [11:0] working_mode;
        logic [11:0] octal_accum;
        logic        octal_overflow;
        phase_t      phase;
        logic [2:0]  who_mask;
        op_t         pending_op;
        logic [11:0] pending_bits;
        logic        exec_allowed;
        logic        dir_flag;
        logic        error_seen;
    } parse_state_t;

    localparam parse_state_t STATE_IDLE = '{
        working_mode:   12'd0,
        octal_accum:    12'd0,
        octal_overflow: 1'b0,
        phase:          PH_START,
        who_mask:       3'd0,
        pending_op:     OP_ADD,
        pending_bits:   12'd0,
        exec_allowed:   1'b0,
        dir_flag:       1'b0,
        error_seen:     1'b0
    };

    // ASCII codes used by the parser.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

endpackage

@@ rtl/core/fmsp_step.sv @@
// ----------------------------------------------------------------------------
// File mode string parser character step
// Combinational next-state and end-of-string result for one character.
// ----------------------------------------------------------------------------
module fmsp_step
    import fmsp_pkg::*;
(
    input  parse_state_t cur,
    input  logic         cnt_full,
    input  in_item_t     item,
    output parse_state_t nxt,
    output out_item_t    result
);

    // No who letters means all of u, g and o.
    function automatic logic [2:0] eff_who(input logic [2:0] mask);
        eff_who = (mask == 3'd0) ? 3'b111 : mask;
    endfunction

    // Place an rwx triple into each selected class.
    function automatic logic [11:0] spread(input logic [2:0] trip, input logic [2:0] who);
        spread = {3'b000,
                  who[0] ? trip : 3'b000,
                  who[1] ? trip : 3'b000,
                  who[2] ? trip : 3'b000};
    endfunction

    // Fold the gathered bits of a segment into the mode.
    function automatic logic [11:0] apply_seg(input logic [11:0] mode, input op_t op,
                                              input logic [11:0] bits,
                                              input logic [2:0] who);
        logic [11:0] clr;
        clr = 12'd0;
        if (who[0]) clr = clr | 12'o4700;
        if (who[1]) clr = clr | 12'o2070;
        if (who[2]) clr = clr | 12'o1007;
        unique case (op)
            OP_ADD:  apply_seg = mode | bits;
            OP_SUB:  apply_seg = mode & ~bits;
            OP_SET:  apply_seg = (mode & ~clr) | bits;
            default: apply_seg = mode;
        endcase
    endfunction

    parse_state_t s;
    logic         err;
    logic         is_op;
    logic [2:0]   who;
    logic [11:0]  seg_mode;
    op_t          new_op;
    logic [11:0]  fin_mode;
    logic [11:0]  mode_out;
    logic         bad;

    // Operator decode for a new segment.
    always_comb
    begin
        is_op = (item.ch == CH_PLUS) || (item.ch == CH_MINUS) || (item.ch == CH_EQ);
        if (item.ch == CH_PLUS)
            new_op = OP_ADD;
        else if (item.ch == CH_MINUS)
            new_op = OP_SUB;
        else
            new_op = OP_SET;
    end

    // Character step.
    always_comb
    begin
        s        = cur;
        err      = cur.error_seen | cnt_full;
        who      = 3'b111;
        seg_mode = 12'd0;

        // First character samples the file data and picks the mode style.
        if (cur.phase == PH_START)
        begin
            s.working_mode = item.current_mode;
            s.dir_flag     = item.is_dir;
            if (item.ch >= CH_0 && item.ch <= CH_9)
                s.phase = PH_OCTAL;
            else
            begin
                s.phase    = PH_WHO;
                s.who_mask = 3'd0;
            end
        end

        who = eff_who(s.who_mask);

        if (!err)
        begin
            if (s.phase == PH_OCTAL)
            begin
                if (item.ch >= CH_0 && item.ch <= CH_7)
                begin
                    if (s.octal_accum[11:9] != 3'd0)
                        s.octal_overflow = 1'b1;
                    s.octal_accum = {s.octal_accum[8:0], item.ch[2:0]};
                end
                else
                    err = 1'b1;
            end
            else if (s.phase == PH_WHO)
            begin
                // Who letters, an operator, or an empty clause.
                priority if (item.ch == CH_LO_U)
                    s.who_mask = s.who_mask | 3'b001;
                else if (item.ch == CH_LO_G)
                    s.who_mask = s.who_mask | 3'b010;
                else if (item.ch == CH_LO_O)
                    s.who_mask = s.who_mask | 3'b100;
                else if (item.ch == CH_LO_A)
                    s.who_mask = 3'b111;
                else if (is_op)
                begin
                    s.pending_op   = new_op;
                    s.pending_bits = 12'd0;
                    s.exec_allowed = s.dir_flag | (|(s.working_mode & 12'o0111));
                    s.phase        = PH_PERM;
                end
                else if (item.ch == CH_COMMA)
                    s.who_mask = 3'd0;
                else
                    err = 1'b1;
            end
            else if (is_op)
            begin
                // Close the running segment and open a new one.
                seg_mode = apply_seg(s.working_mode, s.pending_op, s.pending_bits, who);
                s.working_mode = seg_mode;
                s.pending_op   = new_op;
                s.pending_bits = 12'd0;
                s.exec_allowed = s.dir_flag | (|(seg_mode & 12'o0111));
                s.phase        = PH_PERM;
            end
            else
            begin
                // Permission letters of the running segment.
                unique case (item.ch)
                    CH_COMMA:
                    begin
                        s.working_mode = apply_seg(s.working_mode, s.pending_op,
                                                   s.pending_bits, who);
                        s.pending_bits = 12'd0;
                        s.who_mask     = 3'd0;
                        s.phase        = PH_WHO;
                    end
                    CH_LO_R: s.pending_bits = s.pending_bits | spread(3'b100, who);
                    CH_LO_W: s.pending_bits = s.pending_bits | spread(3'b010, who);
                    CH_LO_X: s.pending_bits = s.pending_bits | spread(3'b001, who);
                    CH_UP_X:
                    begin
                        if (s.exec_allowed)
                            s.pending_bits = s.pending_bits | spread(3'b001, who);
                    end
                    CH_LO_S:
                    begin
                        if (who[0]) s.pending_bits = s.pending_bits | 12'o4000;
                        if (who[1]) s.pending_bits = s.pending_bits | 12'o2000;
                    end
                    CH_LO_T: s.pending_bits = s.pending_bits | 12'o1000;
                    CH_LO_U:
                        s.pending_bits = s.pending_bits | spread(s.working_mode[8:6], who);
                    CH_LO_G:
                        s.pending_bits = s.pending_bits | spread(s.working_mode[5:3], who);
                    CH_LO_O:
                        s.pending_bits = s.pending_bits | spread(s.working_mode[2:0], who);
                    default: err = 1'b1;
                endcase
            end
        end

        s.error_seen = err;
        nxt          = s;
    end

    // Result as it would stand if this character ends the string.
    always_comb
    begin
        if (!s.error_seen && s.phase == PH_PERM)
            fin_mode = apply_seg(s.working_mode, s.pending_op, s.pending_bits, who);
        else
            fin_mode = s.working_mode;
        mode_out         = (s.phase == PH_OCTAL) ? s.octal_accum : fin_mode;
        bad              = s.error_seen | s.octal_overflow;
        result.invalid   = bad;
        result.mode_bits = bad ? 12'd0 : (mode_out & MODE_MASK);
    end

endmodule

@@ rtl/core/fmsp_core.sv @@
// ----------------------------------------------------------------------------
// File mode string parser core
// Parser state and character count registers around the character step.
// ----------------------------------------------------------------------------
module fmsp_core
    import fmsp_pkg::*;
#(
    parameter int MAX_LEN = 255,
    parameter int CNT_W   = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    output out_item_t result
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             cnt_full;

    // Characters past the length limit only mark the string bad.
    assign cnt_full = (count_reg >= CNT_W'(MAX_LEN));

    fmsp_step u_step (
        .cur      (state_reg),
        .cnt_full (cnt_full),
        .item     (item),
        .nxt      (state_next),
        .result   (result)
    );

    // Count update; the last character returns to the start of a string.
    always_comb
    begin
        if (item.last)
            count_next = '0;
        else if (cnt_full)
            count_next = count_reg;
        else
            count_next = count_reg + CNT_W'(1);
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
            count_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= item.last ? STATE_IDLE : state_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/file_mode_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// File mode string parser unit
// Parses a chmod-style mode string, one character per item, into a mode.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on item_valid/item_ready/item, one character each, with
// the file's current mode and directory flag (sampled on a string's first
// character) and a last flag on the final character. Results leave on
// result_valid/result_ready/result, one item per string, with the new mode
// and an invalid flag; the mode reads zero when invalid is set.
// Throughput is one character per cycle, except while a last character waits
// for the result register. An accepted character enters an input register and
// is parsed from there; parsing a last character loads the result register.
// When the receiver stalls, non-final characters keep flowing into the parser
// state; only a last character waits in the input register until the result
// register is free, and the input then stalls behind it.
// Reset clears the valid flags of both registers and returns the parser to the
// start of a string. Strings longer than MAX_LEN characters are reported invalid.
// ----------------------------------------------------------------------------
module file_mode_string_parser_unit
    import fmsp_pkg::*;
#(
    parameter int MAX_LEN = 255
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t step_result;
    logic      out_free;
    logic      step_en;

    // A held character advances unless it ends a string with no room for the result.
    assign out_free   = !out_valid_reg || result_ready;
    assign step_en    = in_valid_reg && (!in_reg.last || out_free);
    assign item_ready = !in_valid_reg || step_en;

    fmsp_core #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_reg),
        .result  (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_reg <= item;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en && in_reg.last)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && in_reg.last)
            out_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A parsed last character always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && in_reg.last |=> result_valid)
        else $error("last character did not produce a result");

    // A last character blocked by a full result register stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_reg.last && out_valid_reg && !result_ready
        |=> in_valid_reg && $stable(in_reg))
        else $error("blocked last character was lost");

    // An invalid result carries a zero mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.invalid |-> result.mode_bits == 12'd0)
        else $error("invalid result with nonzero mode");

    // Non-final characters never wait on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_reg.last |-> step_en && item_ready)
        else $error("non-final character stalled");

endmodule
